@@ src/dttf_pkg.sv @@
package dttf_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_INVALID    = 3'd2,
        ST_FRAC_LIMIT = 3'd3,
        ST_OVERFLOW   = 3'd4
    } status_t;

    // Field widths
    localparam int CHAR_W   = 8;
    localparam int FD_W     = 5;
    localparam int VALUE_W  = 64;
    localparam int STEP_W   = 6;
    localparam int PROD_W   = VALUE_W + 4;
    localparam int M_DATA_W = 72;

    // Command queue depth
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // Characters
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;

    // Largest magnitude that still fits (as a negative value): 2^63
    localparam logic [PROD_W-1:0] MAG_LIMIT = 68'h0_8000_0000_0000_0000;

    localparam logic [FD_W-1:0] FD_RESET = 5'd1;
    localparam logic [FD_W-1:0] PZ_MAX   = 5'd31;

    // Command for the back end: pre_zeros times x10, then x10+digit,
    // then post_zeros times x10; on last, emit a result.
    typedef struct packed {
        logic [FD_W-1:0] pre_zeros;
        logic            has_digit;
        logic [3:0]      digit;
        logic [FD_W-1:0] post_zeros;
        logic            last;
        status_t         early_status;
        logic            negative;
    } cmd_t;

endpackage

@@ src/dttf_front.sv @@
module dttf_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [dttf_pkg::CHAR_W-1:0]  s_tdata,
    input  logic                         s_tlast,
    input  logic                         cfg_we,
    input  logic [dttf_pkg::FD_W-1:0]    cfg_wdata,
    input  logic                         q_full,
    output logic                         q_push,
    output dttf_pkg::cmd_t               q_cmd
);

    typedef enum logic [6:0] {
        PH_LEAD  = 7'b0000001,
        PH_SIGN  = 7'b0000010,
        PH_INT   = 7'b0000100,
        PH_POINT = 7'b0001000,
        PH_FRAC  = 7'b0010000,
        PH_TRAIL = 7'b0100000,
        PH_ERR   = 7'b1000000
    } phase_t;

    phase_t                       phase_reg, phase_next;
    logic                         neg_reg, neg_next;
    logic [dttf_pkg::FD_W-1:0]    fc_reg, fc_next;
    logic [dttf_pkg::FD_W-1:0]    pz_reg, pz_next;
    dttf_pkg::status_t            err_reg, err_next;
    logic [dttf_pkg::FD_W-1:0]    fd_reg;

    logic                         accept;
    logic                         is_dig, is_ws;
    logic [3:0]                   dval;
    logic                         emit_dig;
    logic [dttf_pkg::FD_W-1:0]    pre;
    logic [dttf_pkg::FD_W:0]      frac_need;
    logic                         frac_ok;
    dttf_pkg::status_t            early;
    logic [dttf_pkg::FD_W-1:0]    post;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // Character classes
    assign is_dig = (s_tdata >= dttf_pkg::CH_ZERO) && (s_tdata <= dttf_pkg::CH_NINE);
    assign is_ws  = (s_tdata == dttf_pkg::CH_SPACE) ||
                    ((s_tdata >= dttf_pkg::CH_TAB) && (s_tdata <= dttf_pkg::CH_CR));
    assign dval   = s_tdata[3:0];

    // Fraction digit limit: count + pending zeros + this digit
    assign frac_need = {1'b0, fc_reg} + {1'b0, pz_reg} + {{dttf_pkg::FD_W{1'b0}}, 1'b1};
    assign frac_ok   = frac_need <= {1'b0, fd_reg};

    // Parse step
    always_comb begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        fc_next    = fc_reg;
        pz_next    = pz_reg;
        err_next   = err_reg;
        emit_dig   = 1'b0;
        pre        = '0;
        unique case (phase_reg)
            PH_LEAD: begin
                if (is_dig) begin
                    emit_dig   = 1'b1;
                    phase_next = PH_INT;
                end else if (s_tdata == dttf_pkg::CH_MINUS) begin
                    neg_next   = 1'b1;
                    phase_next = PH_SIGN;
                end else if (s_tdata == dttf_pkg::CH_PLUS) begin
                    phase_next = PH_SIGN;
                end else if (!is_ws) begin
                    phase_next = PH_ERR;
                    err_next   = dttf_pkg::ST_INVALID;
                end
            end
            PH_SIGN: begin
                if (is_dig) begin
                    emit_dig   = 1'b1;
                    phase_next = PH_INT;
                end else begin
                    phase_next = PH_ERR;
                    err_next   = dttf_pkg::ST_INVALID;
                end
            end
            PH_INT: begin
                if (is_dig) begin
                    emit_dig = 1'b1;
                end else if (s_tdata == dttf_pkg::CH_POINT) begin
                    phase_next = PH_POINT;
                end else if (is_ws) begin
                    phase_next = PH_TRAIL;
                end else begin
                    phase_next = PH_ERR;
                    err_next   = dttf_pkg::ST_INVALID;
                end
            end
            PH_POINT, PH_FRAC: begin
                if (is_dig) begin
                    phase_next = PH_FRAC;
                    if (dval == 4'd0) begin
                        pz_next = (pz_reg == dttf_pkg::PZ_MAX) ? pz_reg : pz_reg + 5'd1;
                    end else if (!frac_ok) begin
                        phase_next = PH_ERR;
                        err_next   = dttf_pkg::ST_FRAC_LIMIT;
                    end else begin
                        emit_dig = 1'b1;
                        pre      = pz_reg;
                        fc_next  = frac_need[dttf_pkg::FD_W-1:0];
                        pz_next  = '0;
                    end
                end else if (is_ws && (phase_reg == PH_FRAC)) begin
                    phase_next = PH_TRAIL;
                end else begin
                    phase_next = PH_ERR;
                    err_next   = dttf_pkg::ST_INVALID;
                end
            end
            PH_TRAIL: begin
                if (!is_ws) begin
                    phase_next = PH_ERR;
                    err_next   = dttf_pkg::ST_INVALID;
                end
            end
            PH_ERR: begin
            end
            default: begin
                phase_next = PH_ERR;
                err_next   = dttf_pkg::ST_INVALID;
            end
        endcase
    end

    // Outcome known at the last character, before any arithmetic
    always_comb begin
        priority if (phase_next == PH_LEAD) begin
            early = dttf_pkg::ST_EMPTY;
        end else if (err_next != dttf_pkg::ST_OK) begin
            early = err_next;
        end else if ((phase_next == PH_SIGN) || (phase_next == PH_POINT)) begin
            early = dttf_pkg::ST_INVALID;
        end else begin
            early = dttf_pkg::ST_OK;
        end
        post = (fd_reg > fc_next) ? fd_reg - fc_next : '0;
    end

    // Command to the back end
    always_comb begin
        q_cmd.last         = s_tlast;
        q_cmd.negative     = neg_next;
        q_cmd.digit        = dval;
        q_cmd.early_status = s_tlast ? early : dttf_pkg::ST_OK;
        if (s_tlast && (early != dttf_pkg::ST_OK)) begin
            q_cmd.pre_zeros  = '0;
            q_cmd.has_digit  = 1'b0;
            q_cmd.post_zeros = '0;
        end else begin
            q_cmd.pre_zeros  = pre;
            q_cmd.has_digit  = emit_dig;
            q_cmd.post_zeros = s_tlast ? post : '0;
        end
    end
    assign q_push = accept && (emit_dig || s_tlast);

    // Parse state; cleared after each last character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            neg_reg   <= 1'b0;
            fc_reg    <= '0;
            pz_reg    <= '0;
            err_reg   <= dttf_pkg::ST_OK;
        end else if (accept) begin
            if (s_tlast) begin
                phase_reg <= PH_LEAD;
                neg_reg   <= 1'b0;
                fc_reg    <= '0;
                pz_reg    <= '0;
                err_reg   <= dttf_pkg::ST_OK;
            end else begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                fc_reg    <= fc_next;
                pz_reg    <= pz_next;
                err_reg   <= err_next;
            end
        end
    end

    // Scale register: fraction digits of the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_reg <= dttf_pkg::FD_RESET;
        end else if (cfg_we) begin
            fd_reg <= cfg_wdata;
        end
    end

    a_err_only_in_err_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_ERR) |-> (err_reg == dttf_pkg::ST_OK))
        else $error("error code set outside error phase");

    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command pushed into full queue");

endmodule

@@ src/dttf_queue.sv @@
module dttf_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  dttf_pkg::cmd_t    push_cmd,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output dttf_pkg::cmd_t    head_cmd
);

    dttf_pkg::cmd_t                   entry_reg [dttf_pkg::Q_DEPTH];
    logic [dttf_pkg::Q_PTR_W-1:0]     wr_ptr_reg;
    logic [dttf_pkg::Q_PTR_W-1:0]     rd_ptr_reg;
    logic [dttf_pkg::Q_CNT_W-1:0]     count_reg;
    logic                             do_push, do_pop;

    assign full       = (count_reg == dttf_pkg::Q_CNT_W'(dttf_pkg::Q_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

@@ src/dttf_back.sv @@
module dttf_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  dttf_pkg::cmd_t                head_cmd,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dttf_pkg::M_DATA_W-1:0] m_tdata
);

    logic [dttf_pkg::VALUE_W-1:0]  mag_reg, mag_next;
    logic                          ovf_reg, ovf_next;
    logic [dttf_pkg::STEP_W-1:0]   step_reg;
    logic                          m_valid_reg;
    logic [dttf_pkg::VALUE_W-1:0]  m_value_reg;
    dttf_pkg::status_t             m_status_reg;

    logic [dttf_pkg::STEP_W-1:0]   n_steps;
    logic                          out_free, go, has_op, done;
    logic [3:0]                    d_step;
    logic [dttf_pkg::PROD_W-1:0]   prod;
    dttf_pkg::status_t             fin_status;
    logic [dttf_pkg::VALUE_W-1:0]  fin_value;

    // Steps for the head command
    assign n_steps = dttf_pkg::STEP_W'(head_cmd.pre_zeros)
                   + dttf_pkg::STEP_W'(head_cmd.has_digit)
                   + dttf_pkg::STEP_W'(head_cmd.post_zeros);

    assign out_free = !m_valid_reg || m_tready;
    assign go       = head_valid && (!head_cmd.last || out_free);
    assign has_op   = (step_reg < n_steps) && !ovf_reg;

    // Digit enters right after the pending zeros
    assign d_step = (head_cmd.has_digit &&
                     (step_reg == dttf_pkg::STEP_W'(head_cmd.pre_zeros)))
                    ? head_cmd.digit : 4'd0;

    // magnitude * 10 + d as shift-add
    assign prod = {1'b0, mag_reg, 3'b000} + {3'b000, mag_reg, 1'b0}
                + {{dttf_pkg::VALUE_W{1'b0}}, d_step};

    always_comb begin
        mag_next = mag_reg;
        ovf_next = ovf_reg;
        if (go && has_op) begin
            if (prod > dttf_pkg::MAG_LIMIT) begin
                ovf_next = 1'b1;
            end else begin
                mag_next = prod[dttf_pkg::VALUE_W-1:0];
            end
        end
    end

    // Overflow makes the remaining steps no-ops
    assign done = ({1'b0, step_reg} + 1'b1 >= {1'b0, n_steps}) || ovf_next;
    assign pop  = go && done;

    // Final status and signed value
    always_comb begin
        priority if (head_cmd.early_status != dttf_pkg::ST_OK) begin
            fin_status = head_cmd.early_status;
        end else if (ovf_next || (!head_cmd.negative && mag_next[dttf_pkg::VALUE_W-1])) begin
            fin_status = dttf_pkg::ST_OVERFLOW;
        end else begin
            fin_status = dttf_pkg::ST_OK;
        end
        if (fin_status != dttf_pkg::ST_OK) begin
            fin_value = '0;
        end else if (head_cmd.negative) begin
            fin_value = ~mag_next + 1'b1;
        end else begin
            fin_value = mag_next;
        end
    end

    // Accumulator and step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mag_reg  <= '0;
            ovf_reg  <= 1'b0;
            step_reg <= '0;
        end else if (go) begin
            if (pop) begin
                step_reg <= '0;
            end else begin
                step_reg <= step_reg + 1'b1;
            end
            if (pop && head_cmd.last) begin
                mag_reg <= '0;
                ovf_reg <= 1'b0;
            end else begin
                mag_reg <= mag_next;
                ovf_reg <= ovf_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pop && head_cmd.last) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop && head_cmd.last) begin
            m_value_reg  <= fin_value;
            m_status_reg <= fin_status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b00000, m_status_reg, m_value_reg};

    a_result_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_cmd.last) |-> out_free)
        else $error("result loaded over an untaken result");

    a_mag_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mag_reg[dttf_pkg::VALUE_W-1] |-> (mag_reg[dttf_pkg::VALUE_W-2:0] == '0))
        else $error("magnitude above 2^63");

    a_step_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !head_valid |-> (step_reg == '0))
        else $error("step counter running without a command");

endmodule

@@ src/decimal_text_to_fixed_parser.sv @@
// Decimal text to fixed-point parser.
// Input stream (s_*): one ASCII character per request in s_tdata[7:0],
// s_tlast on the final character of the text. Output stream (m_*): one
// result per text, m_tdata[63:0] = value * 10^scale_digits (signed,
// zero on error), m_tdata[66:64] = status (0 ok, 1 empty, 2 invalid,
// 3 too many fraction digits, 4 overflow).
// scale_digits is written through cfg_we/cfg_wdata while idle: the user
// must see to this, the block does not enforce it. A front stage classifies
// each character in the cycle it is accepted and queues a command; the
// back stage runs one multiply-by-ten step per cycle while it has a
// command and, for a last-character command, room at the output register.
// Throughput: one character per cycle while the queue is not full. A
// nonzero fraction digit runs a back-end step for each held-back zero
// before it and one for itself; the last character adds the steps that
// scale the result to scale_digits places, fewer once overflow is seen.
// The 4-entry queue absorbs these so the input stalls only when it fills.
// Reset clears the parse state, queue and output and sets scale_digits
// to 1. When m_tready is low the result is held and the back stage waits on
// the next last-character command; the input keeps flowing until the queue
// is full.
module decimal_text_to_fixed_parser (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,    // [7:0] text_char
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [71:0]                   m_tdata,    // [63:0] scaled_value, [66:64] status
    input  logic                          cfg_we,
    input  logic [4:0]                    cfg_wdata
);

    logic              q_push, q_full, q_pop, q_head_valid;
    dttf_pkg::cmd_t    q_cmd, q_head;

    dttf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd)
    );

    dttf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head)
    );

    dttf_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_cmd   (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

@@ tb/decimal_text_to_fixed_parser_test.sv @@
`timescale 1ns / 100ps

module decimal_text_to_fixed_parser_test;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 64;    // beyond the longest back-end run for one text
    localparam int LONG_HOLD   = 300;

    localparam logic [63:0] TWO_POW_63 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] INT64_TOP  = 64'h7FFF_FFFF_FFFF_FFFF;

    // Parse phases of the predictor
    typedef enum logic [2:0] {
        SCAN_LEAD, SCAN_SIGN, SCAN_INT, SCAN_POINT, SCAN_FRAC, SCAN_TRAIL, SCAN_ERR
    } scan_phase_t;

    typedef struct packed {
        logic [63:0]       value;
        dttf_pkg::status_t status;
    } parse_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;    // [7:0] text_char
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [71:0] m_tdata;           // [63:0] scaled_value, [66:64] status
    logic        cfg_we    = 1'b0;
    logic [4:0]  cfg_wdata = '0;

    decimal_text_to_fixed_parser dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #4 aclk = ~aclk;

    // Predictor state and register copy
    logic [4:0]        frac_digits_reg;
    scan_phase_t       phase;
    logic [63:0]       mag;
    logic              neg;
    logic              ovf;
    logic [4:0]        frac_cnt;
    logic [4:0]        held_zeros;
    dttf_pkg::status_t first_err;

    parse_result_t parsed_q[$];
    logic [7:0]    text_buf[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    logic rx_hold      = 1'b0;
    event long_hold_ev;

    int cycle_cnt    = 0;
    int err_cnt      = 0;
    int n_chars      = 0;
    int n_texts      = 0;
    int n_cfg_writes = 0;
    int n_in_stalls  = 0;
    int status_seen[5];

    // ---------------- predictor ----------------

    task automatic clear_parse();
        phase      = SCAN_LEAD;
        mag        = '0;
        neg        = 1'b0;
        ovf        = 1'b0;
        frac_cnt   = '0;
        held_zeros = '0;
        first_err  = dttf_pkg::ST_OK;
    endtask

    // magnitude = magnitude*10 + d, sticky overflow past 2^63
    task automatic times_ten_add(input logic [3:0] d);
        if (!ovf) begin
            if (mag > (TWO_POW_63 - 64'(d)) / 64'd10)
                ovf = 1'b1;
            else
                mag = mag * 64'd10 + 64'(d);
        end
    endtask

    task automatic enter_error(input dttf_pkg::status_t code);
        first_err = code;
        phase     = SCAN_ERR;
    endtask

    // Zeros are held back until a nonzero fraction digit arrives
    task automatic take_frac_digit(input logic [3:0] d);
        if (d == 0) begin
            if (held_zeros < dttf_pkg::PZ_MAX)
                held_zeros++;
        end else if (int'(frac_cnt) + int'(held_zeros) + 1 > int'(frac_digits_reg)) begin
            enter_error(dttf_pkg::ST_FRAC_LIMIT);
        end else begin
            for (int k = 0; k < held_zeros; k++)
                times_ten_add(4'd0);
            times_ten_add(d);
            frac_cnt   = 5'(int'(frac_cnt) + int'(held_zeros) + 1);
            held_zeros = '0;
        end
    endtask

    function automatic logic is_space(input logic [7:0] c);
        return c == dttf_pkg::CH_SPACE || (c >= dttf_pkg::CH_TAB && c <= dttf_pkg::CH_CR);
    endfunction

    task automatic scan_char(input logic [7:0] c);
        logic       dig;
        logic       ws;
        logic [3:0] d;
        dig = (c >= dttf_pkg::CH_ZERO && c <= dttf_pkg::CH_NINE);
        ws  = is_space(c);
        d   = dig ? 4'(c - dttf_pkg::CH_ZERO) : 4'd0;
        case (phase)
            SCAN_LEAD: begin
                if (ws) begin
                end else if (dig) begin
                    times_ten_add(d);
                    phase = SCAN_INT;
                end else if (c == dttf_pkg::CH_MINUS) begin
                    neg   = 1'b1;
                    phase = SCAN_SIGN;
                end else if (c == dttf_pkg::CH_PLUS) begin
                    phase = SCAN_SIGN;
                end else begin
                    enter_error(dttf_pkg::ST_INVALID);
                end
            end
            SCAN_SIGN: begin
                if (dig) begin
                    times_ten_add(d);
                    phase = SCAN_INT;
                end else begin
                    enter_error(dttf_pkg::ST_INVALID);
                end
            end
            SCAN_INT: begin
                if (dig) times_ten_add(d);
                else if (c == dttf_pkg::CH_POINT) phase = SCAN_POINT;
                else if (ws) phase = SCAN_TRAIL;
                else enter_error(dttf_pkg::ST_INVALID);
            end
            SCAN_POINT: begin
                if (dig) begin
                    phase = SCAN_FRAC;
                    take_frac_digit(d);
                end else begin
                    enter_error(dttf_pkg::ST_INVALID);
                end
            end
            SCAN_FRAC: begin
                if (dig) take_frac_digit(d);
                else if (ws) phase = SCAN_TRAIL;
                else enter_error(dttf_pkg::ST_INVALID);
            end
            SCAN_TRAIL: begin
                if (!ws) enter_error(dttf_pkg::ST_INVALID);
            end
            default: begin
            end
        endcase
    endtask

    // Close the text: scale, check range, queue the expected result
    task automatic close_text();
        parse_result_t r;
        r.value = '0;
        if (phase == SCAN_LEAD) begin
            r.status = dttf_pkg::ST_EMPTY;
        end else if (first_err != dttf_pkg::ST_OK) begin
            r.status = first_err;
        end else if (phase == SCAN_SIGN || phase == SCAN_POINT) begin
            r.status = dttf_pkg::ST_INVALID;
        end else begin
            for (int k = frac_cnt; k < frac_digits_reg; k++)
                times_ten_add(4'd0);
            if (ovf || (!neg && mag > INT64_TOP)) begin
                r.status = dttf_pkg::ST_OVERFLOW;
            end else begin
                r.status = dttf_pkg::ST_OK;
                r.value  = neg ? -mag : mag;
            end
        end
        parsed_q.push_back(r);
        status_seen[r.status]++;
        n_texts++;
        clear_parse();
    endtask

    // ---------------- driving ----------------

    // One character request; returns in the step of its acceptance with
    // s_tvalid still high, so the caller must follow with data or idle.
    task automatic send_char(input logic [7:0] c, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        n_chars++;
        scan_char(c);
        if (last)
            close_text();
    endtask

    task automatic send_text();
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
    endtask

    task automatic run_text(input string s);
        text_buf.delete();
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        send_text();
    endtask

    // Wait for every expected result, then let the back end settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (parsed_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_scale_digits(input logic [4:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        frac_digits_reg = v;
        n_cfg_writes++;
    endtask

    function automatic logic [7:0] rand_space();
        int r;
        r = $urandom_range(5);
        return (r == 0) ? dttf_pkg::CH_SPACE : 8'(8 + r);   // TAB..CR
    endfunction

    // Mostly well-formed numbers, some broken ones, noise and blank texts
    task automatic build_random_text();
        int          kind;
        int          n;
        int          pos;
        logic [7:0]  ch;
        text_buf.delete();
        kind = $urandom_range(99);
        if (kind < 85) begin
            repeat ($urandom_range(2)) text_buf.push_back(rand_space());
            case ($urandom_range(2))
                0: text_buf.push_back(dttf_pkg::CH_MINUS);
                1: text_buf.push_back(dttf_pkg::CH_PLUS);
                default: begin
                end
            endcase
            n = ($urandom_range(9) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 5);
            repeat (n) text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(9)));
            if ($urandom_range(1)) begin
                text_buf.push_back(dttf_pkg::CH_POINT);
                if ($urandom_range(15) == 0)
                    repeat ($urandom_range(25, 35)) text_buf.push_back(dttf_pkg::CH_ZERO);
                n = $urandom_range(1, (frac_digits_reg > 19) ? 21 : frac_digits_reg + 2);
                repeat (n) begin
                    if ($urandom_range(2) == 0)
                        text_buf.push_back(dttf_pkg::CH_ZERO);
                    else
                        text_buf.push_back(8'(dttf_pkg::CH_ZERO + $urandom_range(9)));
                end
            end
            repeat ($urandom_range(2)) text_buf.push_back(rand_space());
            // broken variant: corrupt, insert, or cut short
            if (kind >= 70) begin
                pos = $urandom_range(text_buf.size() - 1);
                case ($urandom_range(2))
                    0: text_buf[pos] = 8'($urandom_range(255));
                    1: begin
                        case ($urandom_range(3))
                            0: ch = dttf_pkg::CH_POINT;
                            1: ch = dttf_pkg::CH_MINUS;
                            2: ch = dttf_pkg::CH_PLUS;
                            default: ch = dttf_pkg::CH_SPACE;
                        endcase
                        text_buf.insert(pos, ch);
                    end
                    default: begin
                        while (text_buf.size() > pos + 1)
                            void'(text_buf.pop_back());
                    end
                endcase
            end
        end else if (kind < 93) begin
            repeat ($urandom_range(1, 5)) text_buf.push_back(8'($urandom_range(255)));
        end else begin
            repeat ($urandom_range(1, 4)) text_buf.push_back(rand_space());
        end
    endtask

    function automatic logic [4:0] pick_scale_digits();
        case ($urandom_range(11))
            0: return 5'd0;
            1: return 5'd31;
            2: return 5'd18;
            default: return 5'($urandom_range(1, 18));
        endcase
    endfunction

    // ---------------- tests ----------------

    // Reset value of the register and the basic forms and errors
    task automatic test_default_forms();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_text("12.5");
        run_text(" -0.5 ");
        run_text("0");
        run_text("   ");
        run_text("+");
        run_text("-x");
        run_text("1.");
        run_text("1.x");
        run_text(".5");
        run_text("1.25");
        run_text("1.20");
        run_text("a1");
        run_text("1.23x");
        run_text("1 2");
        run_text("99999999999999999999");
        text_buf.delete();
        text_buf.push_back(dttf_pkg::CH_TAB);
        text_buf.push_back(8'h37);
        text_buf.push_back(dttf_pkg::CH_CR);
        send_text();
    endtask

    // Register extremes and the int64 boundaries
    task automatic test_register_extremes();
        set_scale_digits(5'd0);
        run_text("-9223372036854775808");
        run_text("9223372036854775808");
        run_text("9223372036854775807");
        run_text("5.0");
        run_text("5.1");
        set_scale_digits(5'd18);
        run_text("-9.223372036854775808");
        run_text("9.223372036854775808");
        run_text("0.000000000000000001");
        run_text("10");
        run_text("0.0000000000000000000000000000000000001");
        set_scale_digits(5'd31);
        run_text("0");
        run_text("1");
        set_scale_digits(5'd19);
        run_text("0.5");
        set_scale_digits(5'd1);
    endtask

    // Random texts under one idle/stall mix, two register settings
    task automatic test_random_texts(input int idle_pct, input int stall_pct, input int n_items);
        int start;
        for (int half = 0; half < 2; half++) begin
            set_scale_digits(pick_scale_digits());
            send_idle_pct  = idle_pct;
            recv_stall_pct = stall_pct;
            start = n_chars;
            while (n_chars - start < n_items / 2) begin
                build_random_text();
                send_text();
            end
        end
    endtask

    // Receiver holds off while short texts keep coming, filling the block
    task automatic test_output_backpressure();
        set_scale_digits(5'd2);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        -> long_hold_ev;
        repeat (20) begin
            build_random_text();
            send_text();
        end
    endtask

    // ---------------- receiver side ----------------

    always @(long_hold_ev) begin
        rx_hold <= 1'b1;
        repeat (LONG_HOLD) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    always @(posedge aclk)
        m_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);

    // Compare each accepted result with the oldest expectation
    parse_result_t want;
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (parsed_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected result: expected none, got value %0d status %0d",
                         $time, $signed(m_tdata[63:0]), m_tdata[66:64]);
            end else begin
                want = parsed_q.pop_front();
                if (m_tdata[63:0] !== want.value) begin
                    err_cnt++;
                    $display("%0t: scaled_value mismatch: expected %0d, got %0d",
                             $time, $signed(want.value), $signed(m_tdata[63:0]));
                end
                if (m_tdata[66:64] !== want.status) begin
                    err_cnt++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, m_tdata[66:64]);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (aresetn && s_tvalid && !s_tready)
            n_in_stalls <= n_in_stalls + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time, parsed_q.size());
        $display("** decimal_text_to_fixed_parser: FAILED **");
        $finish;
    end

    // ---------------- sequence ----------------

    initial begin
        frac_digits_reg = dttf_pkg::FD_RESET;
        clear_parse();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_forms();
        test_register_extremes();
        test_random_texts(0, 0, 280);
        test_random_texts(78, 0, 280);
        test_random_texts(0, 78, 280);
        test_random_texts(22, 22, 280);
        test_output_backpressure();

        drain();
        $display("Covered %0d texts in %0d characters, %0d register writes, %0d input stall cycles",
                 n_texts, n_chars, n_cfg_writes, n_in_stalls);
        $display("Results: ok %0d, empty %0d, invalid %0d, fraction limit %0d, overflow %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4]);
        if (err_cnt == 0) begin
            $display("** decimal_text_to_fixed_parser: PASSED **");
        end else begin
            $display("** decimal_text_to_fixed_parser: FAILED **");
        end
        $finish;
    end

endmodule
